// ===== design/bwst_pkg.sv =====
// Shared types and constants for the vertex bone weight store.
package bwst_pkg;

  localparam int W_W        = 16;   // weight width, unsigned Q0.16
  localparam int B_W        = 8;    // bone index width
  localparam int VID_W      = 16;   // vertex id width
  localparam int VCNT_W     = 13;   // vertex_count register width
  localparam int OUT_SLOTS  = 4;    // slots shown on the result ports
  localparam int IDX_W      = 2;    // index over the result slots
  localparam int Q_W        = 17;   // quotient width before saturation
  localparam int CNT_W      = 5;    // divider step counter width

  localparam logic [VCNT_W-1:0] VCNT_RESET = 13'd4096;
  localparam logic [W_W-1:0]    W_ZERO     = 16'd0;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } bwst_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } bwst_state_t;

endpackage

// ===== design/bwst_mem.sv =====
// Simple dual-port synchronous memory with registered read data.
module bwst_mem #(
  parameter int AW = 12,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bwst_div.sv =====
// Bit-serial restoring divider for weight normalization, saturating to 16 bits.
module bwst_div #(
  parameter int SUM_W = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SUM_W+bwst_pkg::Q_W-1:0] num,
  input  logic [SUM_W-1:0]              den,
  output logic                          done,
  output logic [bwst_pkg::W_W-1:0]      quot
);
  import bwst_pkg::*;

  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   lo_r, lo_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [SUM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             ge;

  // one quotient bit per step; the upper numerator bits are already below den
  always_comb begin
    trial    = {rem_r, lo_r[Q_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num[SUM_W+Q_W-1:Q_W];
      lo_nxt  = num[Q_W-1:0];
      q_nxt   = '0;
      cnt_nxt = CNT_W'(Q_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      lo_nxt   = {lo_r[Q_W-2:0], 1'b0};
      q_nxt    = {q_r[Q_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  // quotient never exceeds 65536, so the top bit alone flags saturation
  assign quot = q_r[Q_W-1] ? {W_W{1'b1}} : q_r[W_W-1:0];

endmodule

// ===== design/vertex_top4_bone_weight_store_unit.sv =====
// Top level of the per-vertex four-slot bone weight store with normalized readout.
//
// Usage:
//   Requests enter on start/in_* and are taken at a clock edge where start is
//   high and busy is low. in_op = 0 adds (in_bone_index, in_weight) to vertex
//   in_vertex_id; in_op = 1 reads the vertex's slots, normalizes the weights
//   to a sum of one (Q0.16, round half up, saturated) and clears the entry.
//   Out-of-range adds are dropped; an out-of-range read returns all zeros.
//   A read result appears on out_* for exactly one cycle with out_valid high;
//   the receiver cannot stall, so results must be taken when shown.
//   cfg_data is written into vertex_count at any edge with cfg_valid high
//   (cfg_ready is always high); write it only while the block is idle.
// Busy periods:
//   An add keeps busy high after acceptance (memory read, then merge and
//   write back), so a new request is taken only after the write-back.
//   A read keeps busy high while one shared bit-serial divider normalizes
//   min(SLOTS, 4) slots in turn. A zero-sum or out-of-range read skips the
//   divider. The result strobe is the last busy cycle.
// Reset:
//   rst_n clears the control state and vertex_count to 4096, then a clearing
//   pass writes zeros over every store address with busy high.
module vertex_top4_bone_weight_store_unit #(
  parameter int VERTICES = 4096,
  parameter int SLOTS    = 4,
  parameter int BONES    = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [bwst_pkg::VID_W-1:0]    in_vertex_id,
  input  logic [bwst_pkg::B_W-1:0]      in_bone_index,
  input  logic [bwst_pkg::W_W-1:0]      in_weight,
  // result channel
  output logic                          out_valid,
  output logic [bwst_pkg::VID_W-1:0]    out_vertex,
  output logic [bwst_pkg::B_W-1:0]      out_bone_slot_0,
  output logic [bwst_pkg::B_W-1:0]      out_bone_slot_1,
  output logic [bwst_pkg::B_W-1:0]      out_bone_slot_2,
  output logic [bwst_pkg::B_W-1:0]      out_bone_slot_3,
  output logic [bwst_pkg::W_W-1:0]      out_norm_weight_0,
  output logic [bwst_pkg::W_W-1:0]      out_norm_weight_1,
  output logic [bwst_pkg::W_W-1:0]      out_norm_weight_2,
  output logic [bwst_pkg::W_W-1:0]      out_norm_weight_3,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bwst_pkg::VCNT_W-1:0]   cfg_data
);
  import bwst_pkg::*;

  localparam int AW      = $clog2(VERTICES);
  localparam int SUM_W   = W_W + $clog2(SLOTS);
  localparam int NUM_W   = SUM_W + Q_W;
  localparam int BV_W    = SLOTS * B_W;
  localparam int WV_W    = SLOTS * W_W;
  localparam int N_OUT   = (SLOTS < OUT_SLOTS) ? SLOTS : OUT_SLOTS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_OUT - 1);
  localparam logic [AW-1:0]    CLR_LAST = AW'(VERTICES - 1);
  localparam logic [VID_W:0]   VLIM     = (VID_W+1)'(VERTICES);

  bwst_state_t state_r, state_nxt;

  logic [VCNT_W-1:0] vcount_r;
  logic [AW-1:0]     clr_r;
  logic [IDX_W-1:0]  idx_r;

  bwst_op_t          op_r;
  logic [VID_W-1:0]  vid_r;
  logic [B_W-1:0]    bone_r;
  logic [W_W-1:0]    w_r;
  logic              ok_r;

  logic [VID_W:0]    lim;
  logic              rng_ok;
  logic              bone_ok;

  logic              mem_re;
  logic              mem_we;
  logic              wr_zero;
  logic [AW-1:0]     waddr;
  logic [BV_W-1:0]   bones_rd, bones_wr, bones_sh, ins_bones;
  logic [WV_W-1:0]   wts_rd, wts_wr, wts_sh, ins_wts;

  logic [SLOTS-1:0]  slot_open;
  logic              seen;
  logic [SUM_W-1:0]  sum_c;
  logic [SUM_W-1:0]  sum_r;
  logic              read_skip;

  logic [B_W-1:0]    rd_b4 [OUT_SLOTS];
  logic [W_W-1:0]    rd_w4 [OUT_SLOTS];
  logic [B_W-1:0]    ob_r  [OUT_SLOTS];
  logic [W_W-1:0]    ow_r  [OUT_SLOTS];
  logic [W_W-1:0]    nw_r  [OUT_SLOTS];

  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_num;
  logic [W_W-1:0]    div_quot;

  // range checks at acceptance
  assign lim     = ({4'd0, vcount_r} < VLIM) ? {4'd0, vcount_r} : VLIM;
  assign rng_ok  = {1'b0, in_vertex_id} < lim;
  assign bone_ok = 32'(in_bone_index) < 32'(BONES);

  // slot store: bones and weights, same address
  bwst_mem #(.AW(AW), .DW(BV_W)) u_bones (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (bones_wr),
    .re    (mem_re),
    .raddr (in_vertex_id[AW-1:0]),
    .rdata (bones_rd)
  );

  bwst_mem #(.AW(AW), .DW(WV_W)) u_wts (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wts_wr),
    .re    (mem_re),
    .raddr (in_vertex_id[AW-1:0]),
    .rdata (wts_rd)
  );

  // insertion point: first slot that is empty or weaker than the new weight
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_open[i] = (wts_rd[i*W_W +: W_W] == W_ZERO) || (w_r > wts_rd[i*W_W +: W_W]);
    end
  end

  assign bones_sh = bones_rd << B_W;
  assign wts_sh   = wts_rd << W_W;

  // merge: keep slots above, insert, shift the rest down by one
  always_comb begin
    seen      = 1'b0;
    ins_bones = bones_rd;
    ins_wts   = wts_rd;
    for (int i = 0; i < SLOTS; i++) begin
      if (!seen && slot_open[i]) begin
        ins_bones[i*B_W +: B_W] = bone_r;
        ins_wts[i*W_W +: W_W]   = w_r;
      end else if (seen) begin
        ins_bones[i*B_W +: B_W] = bones_sh[i*B_W +: B_W];
        ins_wts[i*W_W +: W_W]   = wts_sh[i*W_W +: W_W];
      end
      seen = seen | slot_open[i];
    end
  end

  // weight sum of the fetched entry
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sum_c = sum_c + SUM_W'(wts_rd[i*W_W +: W_W]);
    end
  end

  assign read_skip = !ok_r || (sum_c == '0);

  // fixed four-slot view of the fetched entry, zero past SLOTS
  for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_view
    if (k < SLOTS) begin : g_have
      assign rd_b4[k] = bones_rd[k*B_W +: B_W];
      assign rd_w4[k] = wts_rd[k*W_W +: W_W];
    end else begin : g_none
      assign rd_b4[k] = '0;
      assign rd_w4[k] = '0;
    end
  end

  // write-back data and address
  assign bones_wr = wr_zero ? '0 : ins_bones;
  assign wts_wr   = wr_zero ? '0 : ins_wts;
  assign waddr    = (state_r == ST_CLEAR) ? clr_r : vid_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE:     if (start) state_nxt = ST_FETCH;
      ST_FETCH: begin
        if (op_r == OP_ADD) begin
          state_nxt = ST_IDLE;
        end else if (read_skip) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (idx_r == LAST_IDX) ? ST_DONE : ST_DIV_GO;
        end
      end
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    wr_zero   = 1'b1;
    div_start = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR:    mem_we = 1'b1;
      ST_IDLE: begin
        busy   = 1'b0;
        mem_re = start;
      end
      ST_FETCH: begin
        mem_we  = ok_r;
        wr_zero = (op_r == OP_READ);
      end
      ST_DIV_GO:   div_start = 1'b1;
      ST_DIV_WAIT: busy = 1'b1;
      ST_DONE:     out_valid = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      idx_r    <= '0;
      vcount_r <= VCNT_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_FETCH) begin
        idx_r <= '0;
      end else if (state_r == ST_DIV_WAIT && div_done) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r   <= bwst_op_t'(in_op);
      vid_r  <= in_vertex_id;
      bone_r <= in_bone_index;
      w_r    <= in_weight;
      ok_r   <= (in_op == OP_READ) ? rng_ok : (rng_ok && bone_ok);
    end
  end

  // read entry capture and normalized results
  always_ff @(posedge clk) begin
    if (state_r == ST_FETCH && op_r == OP_READ) begin
      sum_r <= ok_r ? sum_c : '0;
      for (int k = 0; k < OUT_SLOTS; k++) begin
        ob_r[k] <= ok_r ? rd_b4[k] : '0;
        ow_r[k] <= rd_w4[k];
        nw_r[k] <= '0;
      end
    end else if (state_r == ST_DIV_WAIT && div_done) begin
      nw_r[idx_r] <= div_quot;
    end
  end

  // numerator: w * 65536 + sum / 2, rounding half up
  assign div_num = (NUM_W'(ow_r[idx_r]) << W_W) + NUM_W'(sum_r >> 1);

  bwst_div #(.SUM_W(SUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sum_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign cfg_ready         = 1'b1;
  assign out_vertex        = vid_r;
  assign out_bone_slot_0   = ob_r[0];
  assign out_bone_slot_1   = ob_r[1];
  assign out_bone_slot_2   = ob_r[2];
  assign out_bone_slot_3   = ob_r[3];
  assign out_norm_weight_0 = nw_r[0];
  assign out_norm_weight_1 = nw_r[1];
  assign out_norm_weight_2 = nw_r[2];
  assign out_norm_weight_3 = nw_r[3];

endmodule

// ===== design/bwst_check.sv =====
// Port-level checker for the bone weight store, bound to the top level.
module bwst_check (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // clearing pass keeps the block busy right after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // an accepted request always occupies the block for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // results come only while a request is in progress
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // one strobe per read, and the block is free right after it
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

endmodule

bind vertex_top4_bone_weight_store_unit bwst_check u_bwst_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ===== bench/vertex_top4_bone_weight_store_unit_checker.sv =====
// Checker for the bone weight store: tracks the slot tables and scores every read result.
module vertex_top4_bone_weight_store_unit_checker #(
  parameter int VERTICES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_op,
  input  logic [bwst_pkg::VID_W-1:0]    in_vertex_id,
  input  logic [bwst_pkg::B_W-1:0]      in_bone_index,
  input  logic [bwst_pkg::W_W-1:0]      in_weight,
  input  logic                          out_valid,
  input  logic [bwst_pkg::VID_W-1:0]    out_vertex,
  input  logic [bwst_pkg::B_W-1:0]      out_bone_slot_0,
  input  logic [bwst_pkg::B_W-1:0]      out_bone_slot_1,
  input  logic [bwst_pkg::B_W-1:0]      out_bone_slot_2,
  input  logic [bwst_pkg::B_W-1:0]      out_bone_slot_3,
  input  logic [bwst_pkg::W_W-1:0]      out_norm_weight_0,
  input  logic [bwst_pkg::W_W-1:0]      out_norm_weight_1,
  input  logic [bwst_pkg::W_W-1:0]      out_norm_weight_2,
  input  logic [bwst_pkg::W_W-1:0]      out_norm_weight_3,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bwst_pkg::VCNT_W-1:0]   cfg_data,
  output int                            errors,
  output int                            pending
);
  import bwst_pkg::*;

  typedef struct packed {
    logic [VID_W-1:0]                vertex;
    logic [OUT_SLOTS-1:0][B_W-1:0]   bones;
    logic [OUT_SLOTS-1:0][W_W-1:0]   weights;
  } read_result_t;

  // shadow copy of the slot tables and the vertex limit
  logic [B_W-1:0] bone_mem   [VERTICES][OUT_SLOTS];
  logic [W_W-1:0] weight_mem [VERTICES][OUT_SLOTS];
  int             vertex_limit;
  read_result_t   expected_reads [$];

  // insert before the first empty or weaker slot; the last slot falls out
  task automatic merge_add(input int v, input logic [B_W-1:0] bone, input logic [W_W-1:0] w);
    int i;
    int j;
    bit placed;
    placed = 1'b0;
    for (i = 0; i < OUT_SLOTS; i++) begin
      if (!placed && (weight_mem[v][i] == W_ZERO || w > weight_mem[v][i])) begin
        for (j = OUT_SLOTS - 1; j > i; j--) begin
          bone_mem[v][j]   = bone_mem[v][j-1];
          weight_mem[v][j] = weight_mem[v][j-1];
        end
        bone_mem[v][i]   = bone;
        weight_mem[v][i] = w;
        placed = 1'b1;
      end
    end
  endtask

  // normalize an in-range entry to a sum of one, round half up, saturate; then clear it
  task automatic read_and_clear(input logic [VID_W-1:0] vid, output read_result_t r);
    logic [17:0] total;
    logic [33:0] quot;
    int i;
    r = '0;
    r.vertex = vid;
    if (vid < vertex_limit) begin
      total = '0;
      for (i = 0; i < OUT_SLOTS; i++) total = total + weight_mem[vid][i];
      for (i = 0; i < OUT_SLOTS; i++) begin
        r.bones[i] = bone_mem[vid][i];
        if (total != 0) begin
          quot = (({18'd0, weight_mem[vid][i]} << 16) + {16'd0, total >> 1}) / {16'd0, total};
          r.weights[i] = (quot > 34'd65535) ? 16'hFFFF : quot[W_W-1:0];
        end
        bone_mem[vid][i]   = '0;
        weight_mem[vid][i] = W_ZERO;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    read_result_t want;
    read_result_t got;
    int v;
    int i;
    if (!rst_n) begin
      for (v = 0; v < VERTICES; v++) begin
        for (i = 0; i < OUT_SLOTS; i++) begin
          bone_mem[v][i]   = '0;
          weight_mem[v][i] = W_ZERO;
        end
      end
      vertex_limit = VERTICES;
      expected_reads.delete();
      errors = 0;
    end else begin
      // score the result shown this cycle
      if (out_valid) begin
        got.vertex     = out_vertex;
        got.bones[0]   = out_bone_slot_0;
        got.bones[1]   = out_bone_slot_1;
        got.bones[2]   = out_bone_slot_2;
        got.bones[3]   = out_bone_slot_3;
        got.weights[0] = out_norm_weight_0;
        got.weights[1] = out_norm_weight_1;
        got.weights[2] = out_norm_weight_2;
        got.weights[3] = out_norm_weight_3;
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected result for vertex %0d", $time, got.vertex);
          errors = errors + 1;
        end else begin
          want = expected_reads.pop_front();
          if (got.vertex !== want.vertex) begin
            $display("%0t: out_vertex expected %0d actual %0d", $time, want.vertex, got.vertex);
            errors = errors + 1;
          end
          for (i = 0; i < OUT_SLOTS; i++) begin
            if (got.bones[i] !== want.bones[i]) begin
              $display("%0t: vertex %0d bone_slot_%0d expected %0d actual %0d",
                       $time, want.vertex, i, want.bones[i], got.bones[i]);
              errors = errors + 1;
            end
            if (got.weights[i] !== want.weights[i]) begin
              $display("%0t: vertex %0d norm_weight_%0d expected %0d actual %0d",
                       $time, want.vertex, i, want.weights[i], got.weights[i]);
              errors = errors + 1;
            end
          end
        end
      end

      // track the request taken at this edge, against the limit before any write here
      if (start && !busy) begin
        if (in_op == OP_READ) begin
          read_and_clear(in_vertex_id, want);
          expected_reads.insert(expected_reads.size(), want);
        end else if (in_vertex_id < vertex_limit) begin
          merge_add(int'(in_vertex_id), in_bone_index, in_weight);
        end
      end

      // register write takes effect for later requests
      if (cfg_valid && cfg_ready)
        vertex_limit = (cfg_data < VERTICES) ? cfg_data : VERTICES;
    end
    pending = expected_reads.size();
  end

endmodule

// ===== bench/vertex_top4_bone_weight_store_unit_tb.sv =====
// Testbench top for the bone weight store: clock, reset, request stimulus and verdict.
module vertex_top4_bone_weight_store_unit_tb;
  import bwst_pkg::*;

  localparam int VERTICES    = 4096;
  localparam int STALL_LIMIT = 20000;   // clearing pass plus a full read, with margin

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic                in_op         = OP_ADD;
  logic [VID_W-1:0]    in_vertex_id  = '0;
  logic [B_W-1:0]      in_bone_index = '0;
  logic [W_W-1:0]      in_weight     = '0;
  logic                cfg_valid     = 1'b0;
  logic [VCNT_W-1:0]   cfg_data      = '0;

  logic                busy;
  logic                out_valid;
  logic [VID_W-1:0]    out_vertex;
  logic [B_W-1:0]      out_bone_slot_0, out_bone_slot_1, out_bone_slot_2, out_bone_slot_3;
  logic [W_W-1:0]      out_norm_weight_0, out_norm_weight_1;
  logic [W_W-1:0]      out_norm_weight_2, out_norm_weight_3;
  logic                cfg_ready;

  int                  errors;
  int                  pending;
  int                  stall_cycles = 0;
  int                  tb_limit     = VERTICES;
  int                  items_sent   = 0;
  bit                  fast_mode    = 1'b0;
  logic [W_W-1:0]      last_weight  = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  vertex_top4_bone_weight_store_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_vertex_id      (in_vertex_id),
    .in_bone_index     (in_bone_index),
    .in_weight         (in_weight),
    .out_valid         (out_valid),
    .out_vertex        (out_vertex),
    .out_bone_slot_0   (out_bone_slot_0),
    .out_bone_slot_1   (out_bone_slot_1),
    .out_bone_slot_2   (out_bone_slot_2),
    .out_bone_slot_3   (out_bone_slot_3),
    .out_norm_weight_0 (out_norm_weight_0),
    .out_norm_weight_1 (out_norm_weight_1),
    .out_norm_weight_2 (out_norm_weight_2),
    .out_norm_weight_3 (out_norm_weight_3),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  vertex_top4_bone_weight_store_unit_checker #(.VERTICES(VERTICES)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_vertex_id      (in_vertex_id),
    .in_bone_index     (in_bone_index),
    .in_weight         (in_weight),
    .out_valid         (out_valid),
    .out_vertex        (out_vertex),
    .out_bone_slot_0   (out_bone_slot_0),
    .out_bone_slot_1   (out_bone_slot_1),
    .out_bone_slot_2   (out_bone_slot_2),
    .out_bone_slot_3   (out_bone_slot_3),
    .out_norm_weight_0 (out_norm_weight_0),
    .out_norm_weight_1 (out_norm_weight_1),
    .out_norm_weight_2 (out_norm_weight_2),
    .out_norm_weight_3 (out_norm_weight_3),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .errors            (errors),
    .pending           (pending)
  );

  // watchdog: too long without any request, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[vertex_top4_bone_weight_store_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hold one request until taken, then an optional gap
  task automatic send_request(bwst_op_t op, logic [VID_W-1:0] vid, logic [B_W-1:0] bone,
                              logic [W_W-1:0] wt);
    int gap;
    start         <= 1'b1;
    in_op         <= op;
    in_vertex_id  <= vid;
    in_bone_index <= bone;
    in_weight     <= wt;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = fast_mode ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding read to come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VCNT_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);   // a trailing add leaves no result; let it retire
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tb_limit = (value < VERTICES) ? value : VERTICES;
  endtask

  // mostly a few vertices at either end of the range, sometimes just past it or anywhere
  function automatic logic [VID_W-1:0] pick_vertex();
    int r;
    r = $urandom_range(0, 9);
    if (tb_limit == 0 || r == 0) return VID_W'($urandom);
    if (r == 1) return VID_W'(tb_limit);
    if (r < 6) return VID_W'($urandom_range(0, (tb_limit < 8) ? tb_limit - 1 : 7));
    return VID_W'($urandom_range((tb_limit < 8) ? 0 : tb_limit - 8, tb_limit - 1));
  endfunction

  // zeros, full scale, tiny values and repeats to hit ties and saturation
  function automatic logic [W_W-1:0] draw_weight();
    case ($urandom_range(0, 7))
      0:       last_weight = '0;
      1:       last_weight = 16'hFFFF;
      2:       last_weight = W_W'($urandom_range(1, 15));
      3:       ;
      default: last_weight = W_W'($urandom);
    endcase
    return last_weight;
  endfunction

  // adds to one vertex followed by its read, with stray requests mixed in
  task automatic run_sequences(int budget);
    int stop_at;
    int n;
    int k;
    logic [VID_W-1:0] vid;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      fast_mode = ($urandom_range(0, 9) < 3);
      vid = pick_vertex();
      n = $urandom_range(0, 6);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(bwst_op_t'($urandom_range(0, 1)), VID_W'($urandom),
                       B_W'($urandom), W_W'($urandom));
        else
          send_request(OP_ADD, vid, B_W'($urandom), draw_weight());
      end
      send_request(OP_READ, vid, B_W'($urandom), W_W'($urandom));
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // never-written vertex reads back empty
    send_request(OP_READ, 16'd0, 8'd0, 16'd0);
    // lone slot: quotient overflows and saturates
    send_request(OP_ADD, 16'd0, 8'd1, 16'h8000);
    send_request(OP_READ, 16'd0, 8'hFF, 16'hFFFF);
    // zero weight takes an empty slot; zero sum on read
    send_request(OP_ADD, 16'd1, 8'd7, 16'd0);
    send_request(OP_READ, 16'd1, 8'd0, 16'd0);
    // ordering, tie goes behind, full table drops the weakest
    send_request(OP_ADD, 16'd2, 8'd10, 16'd100);
    send_request(OP_ADD, 16'd2, 8'd11, 16'd300);
    send_request(OP_ADD, 16'd2, 8'd12, 16'd200);
    send_request(OP_ADD, 16'd2, 8'd13, 16'd300);
    send_request(OP_ADD, 16'd2, 8'd14, 16'd50);
    send_request(OP_ADD, 16'd2, 8'd255, 16'hFFFF);
    send_request(OP_READ, 16'd2, 8'd0, 16'd0);
    // last vertex with extreme bones and weights
    send_request(OP_ADD, 16'd4095, 8'd255, 16'hFFFF);
    send_request(OP_ADD, 16'd4095, 8'd0, 16'd1);
    send_request(OP_ADD, 16'd4095, 8'd128, 16'd0);
    send_request(OP_READ, 16'd4095, 8'd0, 16'd0);
    // out-of-range adds are dropped, reads return zeros
    send_request(OP_ADD, 16'd4096, 8'd1, 16'd5);
    send_request(OP_READ, 16'd4096, 8'd0, 16'd0);
    send_request(OP_ADD, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(OP_READ, 16'hFFFF, 8'hFF, 16'hFFFF);
    // zero weight shifts into a slot holding zero
    send_request(OP_ADD, 16'd3, 8'd3, 16'd0);
    send_request(OP_ADD, 16'd3, 8'd4, 16'd0);
    send_request(OP_ADD, 16'd3, 8'd5, 16'd5);
    send_request(OP_READ, 16'd3, 8'd0, 16'd0);

    run_sequences(330);
    write_vertex_count(13'd0);
    run_sequences(60);
    write_vertex_count(13'h1FFF);
    run_sequences(330);
    write_vertex_count(13'd16);
    run_sequences(300);
    write_vertex_count(13'd1);
    run_sequences(150);
    write_vertex_count(13'd4095);
    run_sequences(300);
    write_vertex_count(VCNT_W'($urandom_range(2, 4096)));
    run_sequences(330);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("[vertex_top4_bone_weight_store_unit] OK");
    else
      $display("[vertex_top4_bone_weight_store_unit] ERROR");
    $finish;
  end

endmodule
